### rtl/baro_compensation_altitude_core_defines.svh
// ---------------------------------------------------------------------------
// Barometric altitude core: assertion macros
// Shared assertion wrappers for the checker. Each expands to one labelled
// concurrent assertion clocked on clk.
// ---------------------------------------------------------------------------
`ifndef BARO_COMPENSATION_ALTITUDE_CORE_DEFINES_SVH
`define BARO_COMPENSATION_ALTITUDE_CORE_DEFINES_SVH

// Checked only out of reset
`define BA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define BA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/baro_alt_pkg.sv
// ---------------------------------------------------------------------------
// Barometric altitude package
// Types, register indexes, sequencer states and curve constants.
// ---------------------------------------------------------------------------
package baro_alt_pkg;

    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;
    localparam int RawW     = 24;
    localparam int TempW    = 19;
    localparam int PressW   = 40;
    localparam int AltW     = 32;
    localparam int MulAW    = 41;
    localparam int MulBW    = 32;
    localparam int ProdW    = MulAW + 1 + MulBW;
    localparam int SegN     = 10;
    localparam int SegW     = 4;

    // Register indexes
    localparam logic [CfgIdxW-1:0] CFG_SENS      = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_OFFSET    = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_SENS_TC   = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_OFFSET_TC = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_REF_TEMP  = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_TEMP_SL   = 3'd5;

    localparam logic signed [TempW-1:0] TEMP_BASE = 19'sd2000;
    localparam logic [MulBW-1:0]        P_SCALE   = 32'd10000;

    // Segment start pressures
    localparam logic signed [PressW-1:0] SEG_START [SegN] = '{
        40'sd1013250000, 40'sd954610000, 40'sd898760000, 40'sd845980000,
        40'sd794980000,  40'sd746860000, 40'sd701120000, 40'sd657680000,
        40'sd616450000,  40'sd577330000
    };

    // Altitude at each segment start, 0.1 mm
    localparam logic signed [43:0] SEG_BASE [SegN] = '{
        44'sd0,        44'sd5000000,  44'sd10000000, 44'sd15000000,
        44'sd20000000, 44'sd25000000, 44'sd30000000, 44'sd35000000,
        44'sd40000000, 44'sd45000000
    };

    // Slopes in Q0.32, rounded half up from units of 1e-9
    localparam logic [MulBW-1:0] SEG_SLOPE [SegN] = '{
        32'(((64'd85266030  << 32) + 64'd500000000) / 64'd1000000000),
        32'(((64'd89525515  << 32) + 64'd500000000) / 64'd1000000000),
        32'(((64'd94732853  << 32) + 64'd500000000) / 64'd1000000000),
        32'(((64'd98039216  << 32) + 64'd500000000) / 64'd1000000000),
        32'(((64'd103906899 << 32) + 64'd500000000) / 64'd1000000000),
        32'(((64'd109313511 << 32) + 64'd500000000) / 64'd1000000000),
        32'(((64'd115101289 << 32) + 64'd500000000) / 64'd1000000000),
        32'(((64'd121270919 << 32) + 64'd500000000) / 64'd1000000000),
        32'(((64'd127811861 << 32) + 64'd500000000) / 64'd1000000000),
        32'(((64'd134843581 << 32) + 64'd500000000) / 64'd1000000000)
    };

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TEMP,
        ST_OFF,
        ST_SENS,
        ST_PMUL,
        ST_SCALE,
        ST_SEG,
        ST_ALT,
        ST_HOLD
    } seq_state_t;

    typedef struct packed {
        logic                    start;
        logic signed [MulAW-1:0] a;
        logic [MulBW-1:0]        b;
    } mul_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [ProdW-1:0] prod;
    } mul_rsp_t;

endpackage

### rtl/baro_alt_if.sv
// ---------------------------------------------------------------------------
// Barometric altitude channels
// Valid/ready channels for raw readings in and compensated results out.
// ---------------------------------------------------------------------------
interface baro_alt_in_if
    import baro_alt_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [RawW-1:0]   pressure_raw;
    logic [RawW-1:0]   temp_raw;

    modport source (output valid, output pressure_raw, output temp_raw, input ready);
    modport sink   (input valid, input pressure_raw, input temp_raw, output ready);
endinterface

interface baro_alt_out_if
    import baro_alt_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [TempW-1:0]  temp_centideg;
    logic signed [PressW-1:0] pressure_scaled;
    logic signed [AltW-1:0]   altitude_tenth_mm;

    modport source (output valid, output temp_centideg, output pressure_scaled,
                    output altitude_tenth_mm, input ready);
    modport sink   (input valid, input temp_centideg, input pressure_scaled,
                    input altitude_tenth_mm, output ready);
endinterface

### rtl/baro_alt_mul.sv
// ---------------------------------------------------------------------------
// Bit-serial multiplier
// Signed multiplicand times unsigned multiplier, one multiplier bit per
// cycle, LSB first. 32 steps; done pulses once the product is complete.
// ---------------------------------------------------------------------------
module baro_alt_mul
    import baro_alt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic signed [MulAW-1:0] a_reg;
    logic signed [MulAW:0]   hi_reg;
    logic [MulBW-1:0]        lo_reg;
    logic [4:0]              cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;
    logic signed [MulAW:0]   sum;

    // Partial product add for the current multiplier bit
    assign sum = hi_reg + (lo_reg[0] ? (MulAW+1)'(a_reg) : '0);

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Shift-add datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg  <= req.a;
            hi_reg <= '0;
            lo_reg <= req.b;
        end
        else if (busy_reg)
        begin
            {hi_reg, lo_reg} <= {sum[MulAW], sum, lo_reg[MulBW-1:1]};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.prod = {hi_reg, lo_reg};

endmodule

### rtl/baro_compensation_altitude_core.sv
// An accepted beat runs six products in turn on the shared bit-serial
// multiplier, tries one segment per cycle in the altitude curve search and
// ends with one output load. One item at a time; the next beat is taken
// once the result sits in the output register. Reset clears calibration
// words, the stored temperature reading and all control state.
// ---------------------------------------------------------------------------
// Barometric compensation and altitude core
// First-order pressure/temperature compensation and a ten-segment
// piecewise-linear altitude curve, all products on one serial multiplier.
// ---------------------------------------------------------------------------
module baro_compensation_altitude_core
    import baro_alt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    baro_alt_in_if.sink         in_ch,
    baro_alt_out_if.source      out_ch,
    input  logic                cfg_we,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_data
);

    // Calibration words
    logic [CfgDataW-1:0] sens_reg, offset_reg, sens_tc_reg, offset_tc_reg;
    logic [CfgDataW-1:0] ref_temp_reg, temp_sl_reg;

    logic [RawW-1:0]          prev_temp_reg;
    logic [RawW-1:0]          d1_reg;
    logic signed [25:0]       dt_reg;
    logic signed [TempW-1:0]  temp_reg;
    logic signed [34:0]       off_reg;
    logic signed [34:0]       sens_coef_reg;
    logic signed [PressW-1:0] x_reg;
    logic signed [PressW-1:0] p_reg;
    logic [SegW-1:0]          seg_reg;
    logic signed [AltW-1:0]   alt_reg;
    logic                     launch_reg, launch_next;

    logic                     out_valid_reg;
    logic signed [TempW-1:0]  out_temp_reg;
    logic signed [PressW-1:0] out_press_reg;
    logic signed [AltW-1:0]   out_alt_reg;

    seq_state_t state_reg, state_next;

    mul_req_t mreq;
    mul_rsp_t mrsp;

    logic                     accept;
    logic                     out_load;
    logic [RawW-1:0]          prev_eff;
    logic [RawW:0]            avg_sum;
    logic signed [25:0]       dt_new;
    logic [SegW-1:0]          seg_idx;
    logic                     seg_hit;
    logic signed [MulAW-1:0]  seg_dist;
    logic                     dist_neg;
    logic signed [43:0]       alt_wide;
    logic [MulAW:0]           alt_mag;

    baro_alt_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    assign accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);

    // Temperature average; a stored zero means no earlier reading
    assign prev_eff = (prev_temp_reg == '0) ? in_ch.temp_raw : prev_temp_reg;
    assign avg_sum  = {1'b0, in_ch.temp_raw} + {1'b0, prev_eff};
    assign dt_new   = $signed({2'b00, avg_sum[RawW:1]})
                    - $signed({2'b00, ref_temp_reg, 8'h00});

    // Segment search, one candidate per cycle
    assign seg_idx = (seg_reg == SegW'(SegN - 1)) ? seg_reg : seg_reg + 4'd1;
    assign seg_hit = (seg_reg == SegW'(SegN - 1)) || (p_reg > SEG_START[seg_idx]);

    // Distance into the segment and the altitude sum
    assign seg_dist = MulAW'(SEG_START[seg_reg]) - MulAW'(p_reg);
    assign dist_neg = seg_dist[MulAW-1];
    assign alt_mag  = mrsp.prod[ProdW-1:MulBW];
    assign alt_wide = SEG_BASE[seg_reg]
                    + (dist_neg ? -$signed({2'b00, alt_mag}) : $signed({2'b00, alt_mag}));

    // Sequencer: next state and multiplier request
    always_comb
    begin
        state_next  = state_reg;
        launch_next = 1'b0;
        mreq.start  = launch_reg;
        mreq.a      = MulAW'(dt_reg);
        mreq.b      = '0;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next  = ST_TEMP;
                    launch_next = 1'b1;
                end
            end
            ST_TEMP:
            begin
                mreq.b = MulBW'(temp_sl_reg);
                if (mrsp.done)
                begin
                    state_next  = ST_OFF;
                    launch_next = 1'b1;
                end
            end
            ST_OFF:
            begin
                mreq.b = MulBW'(offset_tc_reg);
                if (mrsp.done)
                begin
                    state_next  = ST_SENS;
                    launch_next = 1'b1;
                end
            end
            ST_SENS:
            begin
                mreq.b = MulBW'(sens_tc_reg);
                if (mrsp.done)
                begin
                    state_next  = ST_PMUL;
                    launch_next = 1'b1;
                end
            end
            ST_PMUL:
            begin
                mreq.a = MulAW'(sens_coef_reg);
                mreq.b = MulBW'(d1_reg);
                if (mrsp.done)
                begin
                    state_next  = ST_SCALE;
                    launch_next = 1'b1;
                end
            end
            ST_SCALE:
            begin
                mreq.a = MulAW'(x_reg);
                mreq.b = P_SCALE;
                if (mrsp.done)
                begin
                    state_next = ST_SEG;
                end
            end
            ST_SEG:
            begin
                if (seg_hit)
                begin
                    state_next  = ST_ALT;
                    launch_next = 1'b1;
                end
            end
            ST_ALT:
            begin
                mreq.a = dist_neg ? -seg_dist : seg_dist;
                mreq.b = SEG_SLOPE[seg_reg];
                if (mrsp.done)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, launch strobe, output valid, stored temperature and calibration words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launch_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_temp_reg <= '0;
            sens_reg      <= '0;
            offset_reg    <= '0;
            sens_tc_reg   <= '0;
            offset_tc_reg <= '0;
            ref_temp_reg  <= '0;
            temp_sl_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= launch_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept)
            begin
                prev_temp_reg <= in_ch.temp_raw;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_SENS:      sens_reg      <= cfg_data;
                    CFG_OFFSET:    offset_reg    <= cfg_data;
                    CFG_SENS_TC:   sens_tc_reg   <= cfg_data;
                    CFG_OFFSET_TC: offset_tc_reg <= cfg_data;
                    CFG_REF_TEMP:  ref_temp_reg  <= cfg_data;
                    CFG_TEMP_SL:   temp_sl_reg   <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    // Datapath captures
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            d1_reg  <= in_ch.pressure_raw;
            dt_reg  <= dt_new;
            seg_reg <= '0;
        end
        if (mrsp.done)
        begin
            case (state_reg)
                ST_TEMP:  temp_reg      <= TempW'(mrsp.prod >>> 23) + TEMP_BASE;
                ST_OFF:   off_reg       <= $signed({3'b000, offset_reg, 16'h0000})
                                         + 35'(mrsp.prod >>> 7);
                ST_SENS:  sens_coef_reg <= $signed({4'b0000, sens_reg, 15'h0000})
                                         + 35'(mrsp.prod >>> 8);
                ST_PMUL:  x_reg         <= PressW'(mrsp.prod >>> 21) - PressW'(off_reg);
                ST_SCALE: p_reg         <= PressW'(mrsp.prod >>> 15);
                ST_ALT:
                begin
                    if (alt_wide > 44'sd2147483647)
                        alt_reg <= 32'sh7FFFFFFF;
                    else if (alt_wide < -44'sd2147483648)
                        alt_reg <= 32'sh80000000;
                    else
                        alt_reg <= AltW'(alt_wide);
                end
                default: ;
            endcase
        end
        if ((state_reg == ST_SEG) && !seg_hit)
        begin
            seg_reg <= seg_reg + 4'd1;
        end
        if (out_load)
        begin
            out_temp_reg  <= temp_reg;
            out_press_reg <= p_reg;
            out_alt_reg   <= alt_reg;
        end
    end

    assign out_ch.valid             = out_valid_reg;
    assign out_ch.temp_centideg     = out_temp_reg;
    assign out_ch.pressure_scaled   = out_press_reg;
    assign out_ch.altitude_tenth_mm = out_alt_reg;

endmodule

### rtl/baro_alt_checker.sv
// ---------------------------------------------------------------------------
// Barometric altitude port checker
// Watches the top-level ports for handshake and sequencing slips.
// ---------------------------------------------------------------------------
`include "baro_compensation_altitude_core_defines.svh"

module baro_alt_checker
    import baro_alt_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [TempW-1:0]  temp_centideg,
    input logic signed [PressW-1:0] pressure_scaled,
    input logic signed [AltW-1:0]   altitude_tenth_mm
);

    // One item at a time: an accepted beat closes the input
    `BA_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "input open during compute")

    // A result only appears after a compute phase
    `BA_ASSERT(a_result_after_work, $rose(out_valid) |-> $past(!in_ready), "result without compute")

    // Stalled result beat holds
    `BA_ASSERT(a_out_stable, (out_valid && !out_ready) |=> ($stable(temp_centideg) && $stable(pressure_scaled) && $stable(altitude_tenth_mm)), "stalled result changed")

    // Nothing offered while in reset
    `BA_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid, "result valid in reset")

endmodule

bind baro_compensation_altitude_core baro_alt_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .temp_centideg     (out_ch.temp_centideg),
    .pressure_scaled   (out_ch.pressure_scaled),
    .altitude_tenth_mm (out_ch.altitude_tenth_mm)
);
